>>> sv/pressure_temperature_compensation_core_defines.svh
// assertion macros for the pressure and temperature compensation core
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_CORE_DEFINES_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_CORE_DEFINES_SVH

// same-cycle implication, ignored while in reset
`define PTC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, also checked across reset
`define PTC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/ptc_pkg.sv
// constants and register indexes for the pressure and temperature compensation core
package ptc_pkg;

    localparam int DIV_W = 64;

    localparam logic [33:0] FINE_OFFSET = 34'd128000;
    localparam logic [20:0] ADC_FULL    = 21'd1048576;
    localparam logic [11:0] PRESS_SCALE = 12'd3125;
    localparam logic [35:0] TEMP_ROUND  = 36'd128;

    typedef enum logic [1:0] {
        REG_CAL_TEMPERATURE   = 2'd0,
        REG_CAL_PRESSURE_LOW  = 2'd1,
        REG_CAL_PRESSURE_HIGH = 2'd2,
        REG_CAL_PRESSURE_NINE = 2'd3
    } cfg_index_t;

endpackage

>>> sv/ptc_divider.sv
// pipelined signed restoring divider, one quotient bit per stage
module ptc_divider #(
    parameter int WIDTH  = ptc_pkg::DIV_W,
    parameter int SIDE_W = 1
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     ce,
    input  logic                     in_valid,
    input  logic        [WIDTH-1:0]  in_num,
    input  logic        [WIDTH-1:0]  in_den,
    input  logic        [SIDE_W-1:0] in_side,
    output logic                     out_valid,
    output logic        [WIDTH-1:0]  out_quot,
    output logic        [SIDE_W-1:0] out_side
);

    logic [WIDTH-1:0]  rem_reg  [0:WIDTH];
    logic [WIDTH-1:0]  nq_reg   [0:WIDTH];
    logic [WIDTH-1:0]  den_reg  [0:WIDTH];
    logic              neg_reg  [0:WIDTH];
    logic [SIDE_W-1:0] side_reg [0:WIDTH];
    logic [WIDTH:0]    vld_reg;
    logic              out_valid_reg;
    logic [WIDTH-1:0]  quot_reg;
    logic [SIDE_W-1:0] oside_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else if (ce) begin
            vld_reg       <= {vld_reg[WIDTH-1:0], in_valid};
            out_valid_reg <= vld_reg[WIDTH];
        end
    end

    // stage 0: magnitudes and quotient sign
    always_ff @(posedge aclk) begin
        if (ce) begin
            rem_reg[0]  <= '0;
            nq_reg[0]   <= in_num[WIDTH-1] ? WIDTH'(-in_num) : in_num;
            den_reg[0]  <= in_den[WIDTH-1] ? WIDTH'(-in_den) : in_den;
            neg_reg[0]  <= in_num[WIDTH-1] ^ in_den[WIDTH-1];
            side_reg[0] <= in_side;
        end
    end

    for (genvar k = 1; k <= WIDTH; k++) begin : g_step
        logic [WIDTH:0] trial;
        logic [WIDTH:0] diff;
        logic           ge;
        assign trial = {rem_reg[k-1], nq_reg[k-1][WIDTH-1]};
        assign diff  = trial - {1'b0, den_reg[k-1]};
        assign ge    = trial >= {1'b0, den_reg[k-1]};
        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[k]  <= ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
                nq_reg[k]   <= {nq_reg[k-1][WIDTH-2:0], ge};
                den_reg[k]  <= den_reg[k-1];
                neg_reg[k]  <= neg_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            quot_reg  <= neg_reg[WIDTH] ? WIDTH'(-nq_reg[WIDTH]) : nq_reg[WIDTH];
            oside_reg <= side_reg[WIDTH];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_quot  = quot_reg;
    assign out_side  = oside_reg;

endmodule

>>> sv/pressure_temperature_compensation_core.sv
// pressure and temperature compensation core, top level
// Usage:
// - calibration is loaded through cfg_we / cfg_addr / cfg_wdata while no item is in flight;
//   index 0 temperature words, 1 and 2 the packed pressure words, 3 the ninth pressure word
// - s_tdata holds raw temperature and pressure; one item per cycle is accepted if s_tready
// - m_tdata carries fine temperature, temperature in 0.01 degC and pressure in Q24.8 pascal;
//   m_tuser is raised when the pressure divisor was zero, with pressure forced to 0
// - from acceptance to m_tvalid an item passes 12 temperature and pressure coefficient
//   stages, 66 stages of the bit-per-stage 64-bit divider, 5 correction stages and
//   the output register
// - throughput is one item per cycle when not stalled, set by the fully pipelined datapath
// - when m_tready is low with a result waiting, the whole pipeline holds and s_tready
//   drops; nothing is lost or repeated
// - reset clears all valid bits and the calibration registers
module pressure_temperature_compensation_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // raw_temperature[19:0], raw_pressure[39:20]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // fine_temperature, temperature_centi, pressure_q24_8
    output logic        m_tuser,   // pressure_invalid
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [63:0] cfg_wdata
);

`include "pressure_temperature_compensation_core_defines.svh"

    typedef struct packed {
        logic [19:0] adc_t;
        logic [19:0] adc_p;
        logic [31:0] ta;
        logic [31:0] td;
        logic [31:0] tm1;
        logic [31:0] tdd;
        logic [31:0] tv1;
        logic [31:0] tm2;
        logic [31:0] fine;
        logic [31:0] temp;
        logic [33:0] v1;
        logic [63:0] sq;
        logic [63:0] v1p5;
        logic [63:0] v1p2;
        logic [63:0] pp_a;
        logic [63:0] pp_b;
        logic [63:0] pp_c;
        logic [63:0] pp_d;
        logic [63:0] s6;
        logic [63:0] s3;
        logic [63:0] v2;
        logic [63:0] w;
        logic [63:0] num;
        logic [63:0] dv;
        logic        invalid;
    } front_t;

    typedef struct packed {
        logic [31:0] fine;
        logic [31:0] temp;
        logic        invalid;
    } side_t;

    typedef struct packed {
        side_t       sd;
        logic [63:0] p;
        logic [63:0] ph;
        logic [63:0] pp_a;
        logic [63:0] pp_b;
        logic [63:0] pp_c;
        logic [63:0] pp_d;
        logic [63:0] a9;
        logic [63:0] w2;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] z;
        logic [63:0] w1;
        logic [63:0] s;
    } back_t;

    localparam int SIDE_W = $bits(side_t);

    logic [47:0] cal_temp_reg;
    logic [63:0] cal_plo_reg;
    logic [63:0] cal_phi_reg;
    logic [15:0] cal_p9_reg;

    logic        ce;
    front_t      fr_reg  [1:12];
    front_t      fr_next [1:12];
    logic [12:1] fv_reg;
    back_t       bk_reg  [2:6];
    back_t       bk_next [2:6];
    logic [6:2]  bv_reg;

    logic              div_valid;
    logic [63:0]       div_quot;
    logic [SIDE_W-1:0] div_side_raw;
    side_t             div_in_side;

    logic        out_valid_reg;
    logic [95:0] out_data_reg;
    logic        out_user_reg;
    logic [31:0] press_next;

    logic [15:0]        t1, p1;
    logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
    logic signed [47:0] m_a, m_b;
    logic [63:0]        m_sq;
    logic signed [31:0] sh12;
    logic signed [31:0] fine_s;
    logic signed [35:0] t5, t5sh;
    logic signed [33:0] vs;
    logic signed [67:0] sq68;
    logic signed [49:0] m50a, m50b;
    logic signed [48:0] pa, pc, ga, ia;
    logic signed [47:0] pb, pd, gb, ib;
    logic [47:0]        c48, d48;
    logic [43:0]        e44, f44;
    logic [63:0]        num0, dvs, sum5, sum6, w2sum;
    logic [63:0]        xy, yz, zz;

    logic signed [35:0] chk_t5, chk_sh;

    assign ce       = !out_valid_reg || m_tready;
    assign s_tready = ce;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_temp_reg <= '0;
            cal_plo_reg  <= '0;
            cal_phi_reg  <= '0;
            cal_p9_reg   <= '0;
        end else if (cfg_we) begin
            unique case (ptc_pkg::cfg_index_t'(cfg_addr))
                ptc_pkg::REG_CAL_TEMPERATURE:   cal_temp_reg <= cfg_wdata[47:0];
                ptc_pkg::REG_CAL_PRESSURE_LOW:  cal_plo_reg  <= cfg_wdata;
                ptc_pkg::REG_CAL_PRESSURE_HIGH: cal_phi_reg  <= cfg_wdata;
                ptc_pkg::REG_CAL_PRESSURE_NINE: cal_p9_reg   <= cfg_wdata[15:0];
            endcase
        end
    end

    assign t1 = cal_temp_reg[15:0];
    assign t2 = $signed(cal_temp_reg[31:16]);
    assign t3 = $signed(cal_temp_reg[47:32]);
    assign p1 = cal_plo_reg[15:0];
    assign p2 = $signed(cal_plo_reg[31:16]);
    assign p3 = $signed(cal_plo_reg[47:32]);
    assign p4 = $signed(cal_plo_reg[63:48]);
    assign p5 = $signed(cal_phi_reg[15:0]);
    assign p6 = $signed(cal_phi_reg[31:16]);
    assign p7 = $signed(cal_phi_reg[47:32]);
    assign p8 = $signed(cal_phi_reg[63:48]);
    assign p9 = $signed(cal_p9_reg);

    always_comb begin
        fr_next[1]       = '0;
        fr_next[1].adc_t = s_tdata[19:0];
        fr_next[1].adc_p = s_tdata[39:20];
        fr_next[1].ta    = 32'(s_tdata[19:3]) - {15'd0, t1, 1'b0};
        fr_next[1].td    = 32'(s_tdata[19:4]) - {16'd0, t1};

        fr_next[2]     = fr_reg[1];
        m_a            = $signed(fr_reg[1].ta) * t2;
        m_sq           = fr_reg[1].td * fr_reg[1].td;
        fr_next[2].tm1 = m_a[31:0];
        fr_next[2].tdd = m_sq[31:0];

        fr_next[3]     = fr_reg[2];
        sh12           = $signed(fr_reg[2].tdd) >>> 12;
        m_b            = sh12 * t3;
        fr_next[3].tm2 = m_b[31:0];
        fr_next[3].tv1 = 32'($signed(fr_reg[2].tm1) >>> 11);

        fr_next[4]      = fr_reg[3];
        fr_next[4].fine = fr_reg[3].tv1 + 32'($signed(fr_reg[3].tm2) >>> 14);

        fr_next[5]      = fr_reg[4];
        fine_s          = $signed(fr_reg[4].fine);
        fr_next[5].v1   = 34'(fine_s) - $signed(ptc_pkg::FINE_OFFSET);
        t5              = 36'(fine_s) * 36'sd5 + $signed(ptc_pkg::TEMP_ROUND);
        t5sh            = t5 >>> 8;
        fr_next[5].temp = t5sh[31:0];

        fr_next[6]      = fr_reg[5];
        vs              = $signed(fr_reg[5].v1);
        sq68            = vs * vs;
        m50a            = vs * p5;
        m50b            = vs * p2;
        fr_next[6].sq   = sq68[63:0];
        fr_next[6].v1p5 = 64'(m50a);
        fr_next[6].v1p2 = 64'(m50b);

        fr_next[7]      = fr_reg[6];
        pa              = $signed({1'b0, fr_reg[6].sq[31:0]}) * p6;
        pb              = $signed(fr_reg[6].sq[63:32]) * p6;
        pc              = $signed({1'b0, fr_reg[6].sq[31:0]}) * p3;
        pd              = $signed(fr_reg[6].sq[63:32]) * p3;
        fr_next[7].pp_a = 64'(pa);
        fr_next[7].pp_b = {pb[31:0], 32'd0};
        fr_next[7].pp_c = 64'(pc);
        fr_next[7].pp_d = {pd[31:0], 32'd0};

        fr_next[8]    = fr_reg[7];
        fr_next[8].s6 = fr_reg[7].pp_a + fr_reg[7].pp_b;
        fr_next[8].s3 = fr_reg[7].pp_c + fr_reg[7].pp_d;

        fr_next[9]    = fr_reg[8];
        fr_next[9].v2 = fr_reg[8].s6 + (fr_reg[8].v1p5 << 17)
                        + (64'(p4) << 35);
        fr_next[9].w  = 64'($signed(fr_reg[8].s3) >>> 8) + (fr_reg[8].v1p2 << 12)
                        + (64'd1 << 47);

        fr_next[10]      = fr_reg[9];
        c48              = fr_reg[9].w[31:0] * p1;
        d48              = fr_reg[9].w[63:32] * p1;
        fr_next[10].pp_a = 64'(c48);
        fr_next[10].pp_b = {d48[31:0], 32'd0};
        num0             = ({43'd0, ptc_pkg::ADC_FULL - {1'b0, fr_reg[9].adc_p}} << 31)
                           - fr_reg[9].v2;
        fr_next[10].num  = num0;

        fr_next[11]      = fr_reg[10];
        fr_next[11].dv   = fr_reg[10].pp_a + fr_reg[10].pp_b;
        e44              = fr_reg[10].num[31:0] * ptc_pkg::PRESS_SCALE;
        f44              = fr_reg[10].num[63:32] * ptc_pkg::PRESS_SCALE;
        fr_next[11].pp_c = 64'(e44);
        fr_next[11].pp_d = {f44[31:0], 32'd0};

        fr_next[12]         = fr_reg[11];
        dvs                 = 64'($signed(fr_reg[11].dv) >>> 33);
        fr_next[12].dv      = dvs;
        fr_next[12].num     = fr_reg[11].pp_c + fr_reg[11].pp_d;
        fr_next[12].invalid = dvs == 64'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg <= '0;
        end else if (ce) begin
            fv_reg <= {fv_reg[11:1], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 1; k <= 12; k++) begin
                fr_reg[k] <= fr_next[k];
            end
        end
    end

    assign div_in_side.fine    = fr_reg[12].fine;
    assign div_in_side.temp    = fr_reg[12].temp;
    assign div_in_side.invalid = fr_reg[12].invalid;

    ptc_divider #(
        .WIDTH  (ptc_pkg::DIV_W),
        .SIDE_W (SIDE_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (fv_reg[12]),
        .in_num    (fr_reg[12].num),
        .in_den    (fr_reg[12].dv),
        .in_side   (div_in_side),
        .out_valid (div_valid),
        .out_quot  (div_quot),
        .out_side  (div_side_raw)
    );

    always_comb begin
        bk_next[2]      = '0;
        bk_next[2].sd   = side_t'(div_side_raw);
        bk_next[2].p    = div_quot;
        bk_next[2].ph   = 64'($signed(div_quot) >>> 13);
        ga              = $signed({1'b0, bk_next[2].ph[31:0]}) * p9;
        gb              = $signed(bk_next[2].ph[63:32]) * p9;
        ia              = $signed({1'b0, div_quot[31:0]}) * p8;
        ib              = $signed(div_quot[63:32]) * p8;
        bk_next[2].pp_a = 64'(ga);
        bk_next[2].pp_b = {gb[31:0], 32'd0};
        bk_next[2].pp_c = 64'(ia);
        bk_next[2].pp_d = {ib[31:0], 32'd0};

        bk_next[3]    = bk_reg[2];
        bk_next[3].a9 = bk_reg[2].pp_a + bk_reg[2].pp_b;
        w2sum         = bk_reg[2].pp_c + bk_reg[2].pp_d;
        bk_next[3].w2 = 64'($signed(w2sum) >>> 19);

        bk_next[4]   = bk_reg[3];
        xy           = bk_reg[3].a9[31:0] * bk_reg[3].ph[31:0];
        yz           = bk_reg[3].a9[31:0] * bk_reg[3].ph[63:32];
        zz           = bk_reg[3].a9[63:32] * bk_reg[3].ph[31:0];
        bk_next[4].x = xy;
        bk_next[4].y = {32'd0, yz[31:0]};
        bk_next[4].z = {32'd0, zz[31:0]};

        bk_next[5]    = bk_reg[4];
        sum5          = bk_reg[4].x + {bk_reg[4].y[31:0] + bk_reg[4].z[31:0], 32'd0};
        bk_next[5].w1 = 64'($signed(sum5) >>> 25);

        bk_next[6]   = bk_reg[5];
        sum6         = bk_reg[5].p + bk_reg[5].w1 + bk_reg[5].w2;
        bk_next[6].s = 64'($signed(sum6) >>> 8) + (64'(p7) << 4);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bv_reg <= '0;
        end else if (ce) begin
            bv_reg <= {bv_reg[5:2], div_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 2; k <= 6; k++) begin
                bk_reg[k] <= bk_next[k];
            end
        end
    end

    always_comb begin
        priority if (bk_reg[6].sd.invalid || bk_reg[6].s[63]) begin
            press_next = '0;
        end else if (|bk_reg[6].s[62:32]) begin
            press_next = '1;
        end else begin
            press_next = bk_reg[6].s[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ce) begin
            out_valid_reg <= bv_reg[6];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            out_data_reg <= {press_next, bk_reg[6].sd.temp, bk_reg[6].sd.fine};
            out_user_reg <= bk_reg[6].sd.invalid;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    assign chk_t5 = 36'($signed(m_tdata[31:0])) * 36'sd5 + $signed(ptc_pkg::TEMP_ROUND);
    assign chk_sh = chk_t5 >>> 8;

    `PTC_ASSERT_NOW(a_invalid_zero, m_tvalid && m_tuser, m_tdata[95:64] == 32'd0, "invalid item with nonzero pressure")
    `PTC_ASSERT_NOW(a_temp_matches_fine, m_tvalid, m_tdata[63:32] == chk_sh[31:0], "temperature disagrees with fine temperature")
    `PTC_ASSERT_NEXT(a_reset_clears, !aresetn, !m_tvalid && !div_valid && (fv_reg == '0), "valid bits survive reset")

endmodule
